### rtl/ncdf_pkg.sv
// shared types, formats and quantized coefficients for the normal cdf pipeline
package ncdf_pkg;

  // fixed-point formats
  localparam int QB    = 28;  // fraction bits of the internal format
  localparam int IN_W  = 20;  // argument width
  localparam int ACC_W = 32;  // horner accumulator, signed
  localparam int V_W   = 30;  // horner variable (y*y or y-2), signed
  localparam int Y_W   = 30;  // half magnitude y below 3.0, unsigned

  localparam logic signed [ACC_W-1:0] QONE    = ACC_W'(1) <<< QB;
  localparam logic [31:0]             SAT_LIM = 32'd3 << QB;

  localparam int LOW_N  = 9;
  localparam int HIGH_N = 15;
  localparam int H_STAGES = HIGH_N - 1;        // horner steps in the pipe
  localparam int LOW_OFS  = HIGH_N - LOW_N;    // low path idles this many steps

  // input register, variable stage, horner steps, select/clamp, output register
  localparam int PIPE_LATENCY = H_STAGES + 4;

  typedef enum logic [1:0] {
    CLS_LOW,
    CLS_HIGH,
    CLS_SAT
  } cls_t;

  typedef struct packed {
    logic valid;
    logic neg;
    cls_t cls;
  } ctl_t;

  // value in units of 1e-12 to Q.28, round to nearest, ties away from zero
  function automatic logic signed [ACC_W-1:0] to_q(input longint c);
    longint unsigned m;
    longint unsigned q;
    m = (c < 0) ? longint'(-c) : c;
    q = (m * 64'd131072 + 64'd244140625) / 64'd488281250;
    return (c < 0) ? ACC_W'(-longint'(q)) : ACC_W'(q);
  endfunction

  // Q.28 product, round to nearest, ties away from zero
  function automatic logic signed [ACC_W-1:0] qmul(input logic signed [ACC_W-1:0] a,
                                                  input logic signed [V_W-1:0] b);
    logic [ACC_W-1:0]     ma;
    logic [V_W-1:0]       mb;
    logic [ACC_W+V_W-1:0] p;
    logic [ACC_W-1:0]     r;
    ma = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    mb = b[V_W-1] ? V_W'(-b) : V_W'(b);
    p  = (ACC_W+V_W)'(ma) * (ACC_W+V_W)'(mb);
    p  = p + ((ACC_W+V_W)'(1) << (QB - 1));
    r  = p[QB+ACC_W-1:QB];
    return (a[ACC_W-1] ^ b[V_W-1]) ? -signed'(r) : signed'(r);
  endfunction

  // highest power first
  localparam logic signed [ACC_W-1:0] LOW_Q [LOW_N] = '{
    to_q(64'sd124818987),      to_q(-64'sd1075204047),   to_q(64'sd5198775019),
    to_q(-64'sd19198292004),   to_q(64'sd59054035642),   to_q(-64'sd151968751364),
    to_q(64'sd319152932694),   to_q(-64'sd531923007300), to_q(64'sd797884560593)
  };

  localparam logic signed [ACC_W-1:0] HIGH_Q [HIGH_N] = '{
    to_q(-64'sd45255659),      to_q(64'sd152529290),     to_q(-64'sd19538132),
    to_q(-64'sd676904986),     to_q(64'sd1390604284),    to_q(-64'sd794620820),
    to_q(-64'sd2034254874),    to_q(64'sd6549791214),    to_q(-64'sd10557625006),
    to_q(64'sd11630447319),    to_q(-64'sd9279453341),   to_q(64'sd5353579108),
    to_q(-64'sd2141268741),    to_q(64'sd535310849),     to_q(64'sd999936657524)
  };

endpackage

### rtl/ncdf_horner_stage.sv
// one registered horner step: acc <= acc*v + c, coefficient chosen by range
module ncdf_horner_stage #(
  parameter int STAGE = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ncdf_pkg::ctl_t                        ctl_in,
  input  logic [ncdf_pkg::Y_W-1:0]              y_in,
  input  logic signed [ncdf_pkg::V_W-1:0]       v_in,
  input  logic signed [ncdf_pkg::ACC_W-1:0]     acc_in,
  output ncdf_pkg::ctl_t                        ctl_out,
  output logic [ncdf_pkg::Y_W-1:0]              y_out,
  output logic signed [ncdf_pkg::V_W-1:0]       v_out,
  output logic signed [ncdf_pkg::ACC_W-1:0]     acc_out
);

  localparam bit LOW_ON = (STAGE > ncdf_pkg::LOW_OFS);
  localparam int LOW_IX = LOW_ON ? (STAGE - ncdf_pkg::LOW_OFS) : 0;
  localparam logic signed [ncdf_pkg::ACC_W-1:0] HIGH_C = ncdf_pkg::HIGH_Q[STAGE];
  localparam logic signed [ncdf_pkg::ACC_W-1:0] LOW_C  = ncdf_pkg::LOW_Q[LOW_IX];

  logic signed [ncdf_pkg::ACC_W-1:0] prod;
  logic signed [ncdf_pkg::ACC_W-1:0] acc_next;

  assign prod = ncdf_pkg::qmul(acc_in, v_in);

  always_comb begin
    case (ctl_in.cls)
      ncdf_pkg::CLS_HIGH: acc_next = prod + HIGH_C;
      ncdf_pkg::CLS_LOW:  acc_next = LOW_ON ? (prod + LOW_C) : acc_in;
      default:            acc_next = acc_in;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.neg <= ctl_in.neg;
    ctl_out.cls <= ctl_in.cls;
    y_out       <= y_in;
    v_out       <= v_in;
    acc_out     <= acc_next;
  end

endmodule

### rtl/normal_cdf_poly_approx_top.sv
// normal cdf, polynomial form: signed z in, P(Z<=z) rounded to OUT_FRAC_BITS out
// throughput: one request per cycle, set by a 14-step registered horner chain
// busy is high only while rst is high; the receiver cannot stall, so done is a one-cycle strobe
// reset: synchronous, clears every stage's valid bit, so no done until new requests arrive
module normal_cdf_poly_approx_top #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ncdf_pkg::IN_W-1:0] z_value,
  output logic                          done,
  output logic [OUT_FRAC_BITS:0]        probability
);

  // y = |z|/2 in Q.28; the argument LSB lands at bit QB-1-IN_FRAC_BITS
  localparam int SH    = ncdf_pkg::QB - 1 - IN_FRAC_BITS;
  localparam int YE_W  = ncdf_pkg::IN_W + SH;
  localparam int CMP_W = (YE_W > 32) ? YE_W : 32;
  localparam int NUM_W = ncdf_pkg::QB + 2;   // probability in Q.29, up to 1.0
  localparam logic [NUM_W-1:0] RND = NUM_W'(1) << (ncdf_pkg::QB - OUT_FRAC_BITS);

  // requests are refused only while reset is held
  assign busy = rst;

  // ---------------------------------------------------------------------
  // input stage: magnitude, half scaling and range class
  // ---------------------------------------------------------------------
  logic [ncdf_pkg::IN_W-1:0] mag;
  logic [CMP_W-1:0]          y_ext;
  ncdf_pkg::cls_t            cls_in;

  // most negative code reads as 2^19, which lands in the saturated range
  assign mag   = z_value[ncdf_pkg::IN_W-1] ? ncdf_pkg::IN_W'(-z_value)
                                           : ncdf_pkg::IN_W'(z_value);
  assign y_ext = CMP_W'(mag) << SH;

  always_comb begin
    if (y_ext >= CMP_W'(ncdf_pkg::SAT_LIM)) begin
      cls_in = ncdf_pkg::CLS_SAT;
    end else if (y_ext < CMP_W'(ncdf_pkg::QONE)) begin
      cls_in = ncdf_pkg::CLS_LOW;    // zero argument takes this path and gives x = 0
    end else begin
      cls_in = ncdf_pkg::CLS_HIGH;
    end
  end

  ncdf_pkg::ctl_t            a_ctl;
  logic [ncdf_pkg::Y_W-1:0]  a_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl.valid <= 1'b0;
    end else begin
      a_ctl.valid <= start && !busy;
    end
    a_ctl.neg <= z_value[ncdf_pkg::IN_W-1];
    a_ctl.cls <= cls_in;
    a_y       <= y_ext[ncdf_pkg::Y_W-1:0];
  end

  // ---------------------------------------------------------------------
  // variable stage: y*y below 1, y-2 from 1 to 3; seed the accumulator
  // ---------------------------------------------------------------------
  logic signed [ncdf_pkg::V_W-1:0]   v_next;
  logic signed [ncdf_pkg::ACC_W-1:0] seed;
  logic signed [ncdf_pkg::ACC_W-1:0] ysq;

  assign ysq = ncdf_pkg::qmul(signed'(ncdf_pkg::ACC_W'(a_y)), signed'(a_y));

  always_comb begin
    case (a_ctl.cls)
      ncdf_pkg::CLS_LOW: begin
        v_next = ncdf_pkg::V_W'(ysq);
        seed   = ncdf_pkg::LOW_Q[0];
      end
      ncdf_pkg::CLS_HIGH: begin
        v_next = signed'(a_y) - signed'(ncdf_pkg::V_W'(ncdf_pkg::QONE) <<< 1);
        seed   = ncdf_pkg::HIGH_Q[0];
      end
      default: begin
        v_next = '0;
        seed   = '0;
      end
    endcase
  end

  // horner chain signals; index 0 is the variable stage output
  ncdf_pkg::ctl_t                    h_ctl [ncdf_pkg::H_STAGES+1];
  logic [ncdf_pkg::Y_W-1:0]          h_y   [ncdf_pkg::H_STAGES+1];
  logic signed [ncdf_pkg::V_W-1:0]   h_v   [ncdf_pkg::H_STAGES+1];
  logic signed [ncdf_pkg::ACC_W-1:0] h_acc [ncdf_pkg::H_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      h_ctl[0].valid <= 1'b0;
    end else begin
      h_ctl[0].valid <= a_ctl.valid;
    end
    h_ctl[0].neg <= a_ctl.neg;
    h_ctl[0].cls <= a_ctl.cls;
    h_y[0]       <= a_y;
    h_v[0]       <= v_next;
    h_acc[0]     <= seed;
  end

  // ---------------------------------------------------------------------
  // horner steps: the high path uses all of them, the low path the last eight
  // ---------------------------------------------------------------------
  for (genvar k = 1; k <= ncdf_pkg::H_STAGES; k++) begin : g_horner
    ncdf_horner_stage #(
      .STAGE (k)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (h_ctl[k-1]),
      .y_in    (h_y[k-1]),
      .v_in    (h_v[k-1]),
      .acc_in  (h_acc[k-1]),
      .ctl_out (h_ctl[k]),
      .y_out   (h_y[k]),
      .v_out   (h_v[k]),
      .acc_out (h_acc[k])
    );
  end

  // ---------------------------------------------------------------------
  // select stage: 2*y*P1 below 1, P2 from 1 to 3, one beyond; clamp to 0..1
  // ---------------------------------------------------------------------
  localparam int HL = ncdf_pkg::H_STAGES;

  logic signed [ncdf_pkg::ACC_W-1:0] low_prod;
  logic signed [ncdf_pkg::ACC_W-1:0] x_raw;
  logic [ncdf_pkg::QB:0]             x_next;

  assign low_prod = ncdf_pkg::qmul(h_acc[HL], signed'(h_y[HL]));

  always_comb begin
    case (h_ctl[HL].cls)
      ncdf_pkg::CLS_LOW:  x_raw = low_prod <<< 1;   // exact doubling
      ncdf_pkg::CLS_HIGH: x_raw = h_acc[HL];
      default:            x_raw = ncdf_pkg::QONE;
    endcase
    if (x_raw < 0) begin
      x_next = '0;
    end else if (x_raw > ncdf_pkg::QONE) begin
      x_next = (ncdf_pkg::QB+1)'(ncdf_pkg::QONE);
    end else begin
      x_next = x_raw[ncdf_pkg::QB:0];
    end
  end

  logic                  f_valid;
  logic                  f_neg;
  logic [ncdf_pkg::QB:0] f_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= h_ctl[HL].valid;
    end
    f_neg <= h_ctl[HL].neg;
    f_x   <= x_next;
  end

  // ---------------------------------------------------------------------
  // output stage: (1 +/- x)/2, round half up to OUT_FRAC_BITS
  // ---------------------------------------------------------------------
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] num_rnd;

  assign num     = f_neg ? (NUM_W'(ncdf_pkg::QONE) - NUM_W'(f_x))
                         : (NUM_W'(ncdf_pkg::QONE) + NUM_W'(f_x));
  assign num_rnd = num + RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_valid;
    end
    probability <= num_rnd[NUM_W-1 -: OUT_FRAC_BITS+1];
  end

endmodule

### rtl/ncdf_checker.sv
// port-level checks for the normal cdf pipeline, bound to the top level
module ncdf_checker #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 20
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic signed [ncdf_pkg::IN_W-1:0]  z_value,
  input logic                              done,
  input logic [OUT_FRAC_BITS:0]            probability
);

  localparam int LAT = ncdf_pkg::PIPE_LATENCY;
  localparam logic [OUT_FRAC_BITS:0] P_ONE  = (OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS;
  localparam logic [OUT_FRAC_BITS:0] P_HALF = (OUT_FRAC_BITS+1)'(1) << (OUT_FRAC_BITS - 1);
  localparam longint SAT_Z = longint'(6) << IN_FRAC_BITS;

  logic req;
  assign req = start && !busy;

  // every request yields a result a fixed time later
  a_req_done: assert property (@(posedge clk) disable iff (rst) req |-> ##LAT done)
    else $error("request without result");

  // no result without a request at the fixed distance
  a_done_req: assert property (@(posedge clk) disable iff (rst) done |-> $past(req, LAT))
    else $error("result without request");

  // the probability never leaves 0..1
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (probability <= P_ONE))
    else $error("probability above one");

  // a zero argument gives exactly one half
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (req && (z_value == '0)) |-> ##LAT (done && (probability == P_HALF)))
    else $error("zero argument not one half");

  // a large positive argument saturates to one
  a_sat: assert property (@(posedge clk) disable iff (rst)
    (req && (longint'(z_value) >= SAT_Z)) |-> ##LAT (done && (probability == P_ONE)))
    else $error("large argument not saturated");

endmodule

bind normal_cdf_poly_approx_top ncdf_checker #(
  .IN_FRAC_BITS  (IN_FRAC_BITS),
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_ncdf_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .z_value     (z_value),
  .done        (done),
  .probability (probability)
);

### test/normal_cdf_poly_approx_top_test.sv
// self-checking testbench for the normal cdf polynomial pipeline
module normal_cdf_poly_approx_top_test;

  localparam int IN_FRAC  = 16;
  localparam int OUT_FRAC = 20;
  localparam int ZW       = ncdf_pkg::IN_W;

  // internal fixed point: 28 fraction bits, same as the block's horner chain
  localparam int     FB       = 28;
  localparam longint Q_ONE    = 64'sd1 << FB;
  localparam int     OUT_SHFT = FB + 1 - OUT_FRAC;

  // wait after the last answer comes back, leave some slack
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 50000;
  localparam int RAND_ITEMS   = 450;

  // argument codes at the edges of the polynomial ranges
  localparam int Y_ONE_CODE   = 1 << (IN_FRAC + 1);      // |z| = 2.0, y = 1
  localparam int Y_THREE_CODE = 3 << (IN_FRAC + 1);      // |z| = 6.0, y = 3
  localparam int Z_MAX_CODE   = (1 << (ZW - 1)) - 1;

  // series weights in units of 1e-12, highest power first
  localparam longint SMALL_Y_WTS [9] = '{
    64'sd124818987, -64'sd1075204047, 64'sd5198775019, -64'sd19198292004,
    64'sd59054035642, -64'sd151968751364, 64'sd319152932694, -64'sd531923007300,
    64'sd797884560593
  };
  localparam longint MID_Y_WTS [15] = '{
    -64'sd45255659, 64'sd152529290, -64'sd19538132, -64'sd676904986,
    64'sd1390604284, -64'sd794620820, -64'sd2034254874, 64'sd6549791214,
    -64'sd10557625006, 64'sd11630447319, -64'sd9279453341, 64'sd5353579108,
    -64'sd2141268741, 64'sd535310849, 64'sd999936657524
  };

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [ZW-1:0]    z_value;
  logic                    done;
  logic [OUT_FRAC:0]       probability;

  normal_cdf_poly_approx_top #(
    .IN_FRAC_BITS (IN_FRAC),
    .OUT_FRAC_BITS(OUT_FRAC)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .z_value    (z_value),
    .done       (done),
    .probability(probability)
  );

  // one directed request; known marks rows whose answer is obvious by hand
  typedef struct {
    logic signed [ZW-1:0] z;
    bit                   known;
    logic [OUT_FRAC:0]    prob;
  } cdf_row_t;

  cdf_row_t directed_rows [20] = '{
    '{20'sd0,       1'b1, 21'd524288},   // zero argument is exactly one half
    '{20'sd1,       1'b0, 21'd0},        // smallest magnitudes
    '{-20'sd1,      1'b0, 21'd0},
    '{-20'sd2,      1'b0, 21'd0},
    '{20'sd500,     1'b0, 21'd0},
    '{20'sd65536,   1'b0, 21'd0},        // z = +-1.0
    '{-20'sd65536,  1'b0, 21'd0},
    '{20'sd131071,  1'b0, 21'd0},        // last code of the short series
    '{20'sd131072,  1'b0, 21'd0},        // first code of the long series
    '{-20'sd131072, 1'b0, 21'd0},
    '{20'sd196608,  1'b0, 21'd0},        // z = +-3.0
    '{-20'sd196608, 1'b0, 21'd0},
    '{20'sd262143,  1'b0, 21'd0},
    '{20'sd393215,  1'b0, 21'd0},        // top of the long series, may overshoot
    '{-20'sd393215, 1'b0, 21'd0},
    '{20'sd327680,  1'b0, 21'd0},        // z = 5.0
    '{20'sd393216,  1'b1, 21'd1048576},  // |z| = 6.0 saturates
    '{-20'sd393216, 1'b1, 21'd0},
    '{20'sd524287,  1'b1, 21'd1048576},  // most positive code
    '{-20'sd524288, 1'b1, 21'd0}         // most negative code, magnitude 8.0
  };

  logic [OUT_FRAC:0] probs_pending [$];
  int                failures;
  int                cycle_count;

  // weight in units of 1e-12 to q28, nearest, ties away from zero
  // 2^28 / 1e12 reduces to 2^17 / (2 * 5^12), which keeps the product in 64 bits
  function automatic longint weight_q28(input longint w);
    longint unsigned mag;
    longint unsigned q;
    mag = (w < 0) ? -w : w;
    q   = (mag * 64'd131072 + 64'd244140625) / 64'd488281250;
    return (w < 0) ? -longint'(q) : longint'(q);
  endfunction

  // q28 product, nearest, ties away from zero
  function automatic longint q28_mul(input longint a, input longint b);
    logic            flip;
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    flip = (a < 0) != (b < 0);
    ma   = (a < 0) ? -a : a;
    mb   = (b < 0) ? -b : b;
    p    = (ma * mb + (64'd1 << (FB - 1))) >> FB;
    return flip ? -longint'(p) : longint'(p);
  endfunction

  // P(Z <= z) in OUT_FRAC fraction bits
  function automatic logic [OUT_FRAC:0] cdf_expected(input logic signed [ZW-1:0] z);
    logic            below;
    longint          mag;
    longint          y;
    longint          w;
    longint          acc;
    longint          x;
    longint          prob_q29;
    longint unsigned rounded;
    below = z[ZW-1];
    mag   = below ? -longint'(z) : longint'(z);
    if (mag == 0) begin
      x = 0;
    end else begin
      y = mag << (FB - 1 - IN_FRAC);   // half of |z|, exact
      if (y >= 3 * Q_ONE) begin
        x = Q_ONE;
      end else if (y < Q_ONE) begin
        // odd series: 2 * y * P(y^2)
        w   = q28_mul(y, y);
        acc = weight_q28(SMALL_Y_WTS[0]);
        for (int i = 1; i < 9; i++) acc = q28_mul(acc, w) + weight_q28(SMALL_Y_WTS[i]);
        x = 2 * q28_mul(acc, y);
      end else begin
        // series around y = 2
        acc = weight_q28(MID_Y_WTS[0]);
        for (int i = 1; i < 15; i++) begin
          acc = q28_mul(acc, y - 2 * Q_ONE) + weight_q28(MID_Y_WTS[i]);
        end
        x = acc;
      end
    end
    // clamp any polynomial overshoot to 0..1
    if (x < 0) x = 0;
    if (x > Q_ONE) x = Q_ONE;
    prob_q29 = below ? (Q_ONE - x) : (Q_ONE + x);
    rounded  = (prob_q29 + (64'sd1 << (OUT_SHFT - 1))) >> OUT_SHFT;
    return rounded[OUT_FRAC:0];
  endfunction

  // random argument, spread over the ranges and their edges
  function automatic logic signed [ZW-1:0] pick_z();
    int mag;
    int base;
    case ($urandom_range(5))
      0, 1: return ZW'($urandom);
      2: mag = $urandom_range(Y_ONE_CODE - 1, 1);
      3: mag = $urandom_range(Y_THREE_CODE - 1, Y_ONE_CODE);
      4: mag = $urandom_range(Z_MAX_CODE, Y_THREE_CODE);
      default: begin
        case ($urandom_range(2))
          0: base = 0;
          1: base = Y_ONE_CODE;
          default: base = Y_THREE_CODE;
        endcase
        mag = base + $urandom_range(16) - 8;
        if (mag < 0) mag = -mag;
      end
    endcase
    return $urandom_range(1) ? -(ZW'(mag)) : ZW'(mag);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, counted in clocks
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // every done strobe is checked against the oldest outstanding request
  always @(posedge clk) begin
    logic [OUT_FRAC:0] want;
    if (!rst && done) begin
      if (probs_pending.size() == 0) begin
        $error("probability: no request outstanding, got %0d", probability);
        failures++;
      end else begin
        want = probs_pending.pop_front();
        if (probability !== want) begin
          $error("probability: expected %0d, got %0d", want, probability);
          failures++;
        end
      end
    end
  end

  // hold one request until the block takes it, then queue its answer
  task automatic send_request(input logic signed [ZW-1:0] z, input bit known,
                              input logic [OUT_FRAC:0] prob);
    start   <= 1'b1;
    z_value <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    probs_pending.push_back(known ? prob : cdf_expected(z));
  endtask

  // sender gap; idle_pct chances in a hundred
  task automatic maybe_idle(input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      z_value <= ZW'($urandom);
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  initial begin
    int idle_pct;
    failures    = 0;
    cycle_count = 0;
    rst         = 1'b1;
    start       = 1'b0;
    z_value     = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, back to back with light gaps
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].z, directed_rows[i].known, directed_rows[i].prob);
      maybe_idle(6);
    end

    // random part in three phases: rare gaps, frequent gaps, none
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n < RAND_ITEMS / 3) idle_pct = 6;
      else if (n < 2 * RAND_ITEMS / 3) idle_pct = 84;
      else idle_pct = 0;
      send_request(pick_z(), 1'b0, '0);
      maybe_idle(idle_pct);
    end
    start <= 1'b0;

    // drain the pipe, then watch for stray strobes
    while (probs_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
